// ===== src/sse_pkg.sv =====
// ----------------------------------------------------------------------------
// sse_pkg
// Types and constants shared by the SQL statement end scanner modules.
// ----------------------------------------------------------------------------
package sse_pkg;

  typedef enum logic [2:0] {
    MODE_CODE       = 3'd0,
    MODE_DASH       = 3'd1,
    MODE_SLASH      = 3'd2,
    MODE_STRING     = 3'd3,
    MODE_LINE       = 3'd4,
    MODE_BLOCK      = 3'd5,
    MODE_BLOCK_STAR = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_BEGIN = 2'd1,
    PEND_END   = 2'd2
  } pend_t;

  localparam logic [1:0] REGION_CODE   = 2'd0;
  localparam logic [1:0] REGION_STRING = 2'd1;
  localparam logic [1:0] REGION_LINE   = 2'd2;
  localparam logic [1:0] REGION_BLOCK  = 2'd3;

  localparam logic [2:0] WORD_MAX  = 3'd6;
  localparam logic [2:0] WORD_LONG = 3'd7;

  localparam logic [47:0] KW_BEGIN  = 48'h00_42_45_47_49_4E;
  localparam logic [47:0] KW_END    = 48'h00_00_00_45_4E_44;
  localparam logic [47:0] KW_WORK   = 48'h00_00_57_4F_52_4B;
  localparam logic [47:0] KW_IF     = 48'h00_00_00_00_49_46;
  localparam logic [47:0] KW_WHILE  = 48'h00_57_48_49_4C_45;
  localparam logic [47:0] KW_LOOP   = 48'h00_00_4C_4F_4F_50;
  localparam logic [47:0] KW_REPEAT = 48'h52_45_50_45_41_54;
  localparam logic [47:0] KW_CASE   = 48'h00_00_43_41_53_45;

  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef struct packed {
    mode_t       mode;
    logic [47:0] word_chars;
    logic [2:0]  word_length;
    pend_t       pending;
  } scan_state_t;

  typedef struct packed {
    logic       statement_end;
    logic [7:0] nesting_depth;
    logic [1:0] scan_region;
  } scan_result_t;

  function automatic logic is_upper(input logic [7:0] b);
    return (b >= 8'h41) && (b <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [7:0] b);
    return (b >= 8'h61) && (b <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic word_is(input logic [47:0] chars, input logic [2:0] len,
                                   input logic [47:0] kw, input logic [2:0] kw_len);
    return (len == kw_len) && (chars == kw);
  endfunction

endpackage

// ===== src/sse_step.sv =====
// ----------------------------------------------------------------------------
// sse_step
// Next-state and result logic for one text byte of the statement end scanner.
// ----------------------------------------------------------------------------
module sse_step #(
  parameter int MAX_DEPTH = 255
) (
  input  logic [7:0]                        text_byte,
  input  logic                              session_start,
  input  sse_pkg::scan_state_t              state,
  input  logic [$clog2(MAX_DEPTH+1)-1:0]    depth,
  output sse_pkg::scan_state_t              state_next,
  output logic [$clog2(MAX_DEPTH+1)-1:0]    depth_next,
  output sse_pkg::scan_result_t             result
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);

  function automatic logic [DEPTH_W-1:0] nest(input logic [DEPTH_W-1:0] d);
    return (d < DEPTH_LIMIT) ? d + DEPTH_W'(1) : d;
  endfunction

  function automatic logic [DEPTH_W-1:0] unnest(input logic [DEPTH_W-1:0] d);
    return (d != '0) ? d - DEPTH_W'(1) : d;
  endfunction

  sse_pkg::mode_t mode;
  sse_pkg::pend_t pend;
  logic [47:0]    wchars;
  logic [2:0]     wlen;
  logic [DEPTH_W-1:0] d;
  logic           o_end;
  logic [1:0]     o_region;
  logic           do_code;
  logic           skip;
  logic           letter;
  logic           word_char;
  logic [7:0]     upper;
  logic [16:0]    depth_wide;

  always_comb begin
    letter    = sse_pkg::is_upper(text_byte) || sse_pkg::is_lower(text_byte);
    word_char = letter || sse_pkg::is_digit(text_byte) || (text_byte == sse_pkg::CH_UNDER);
    upper     = sse_pkg::is_lower(text_byte) ? text_byte - 8'd32 : text_byte;

    if (session_start) begin
      mode   = sse_pkg::MODE_CODE;
      wchars = '0;
      wlen   = '0;
      pend   = sse_pkg::PEND_NONE;
      d      = '0;
    end else begin
      mode   = state.mode;
      wchars = state.word_chars;
      wlen   = state.word_length;
      pend   = state.pending;
      d      = depth;
    end

    o_end    = 1'b0;
    o_region = sse_pkg::REGION_CODE;
    do_code  = 1'b0;
    skip     = 1'b0;

    case (mode)
      sse_pkg::MODE_DASH: begin
        mode = sse_pkg::MODE_CODE;
        if (text_byte == sse_pkg::CH_DASH) begin
          mode     = sse_pkg::MODE_LINE;
          o_region = sse_pkg::REGION_LINE;
        end else begin
          do_code = 1'b1;
        end
      end
      sse_pkg::MODE_SLASH: begin
        mode = sse_pkg::MODE_CODE;
        if (text_byte == sse_pkg::CH_STAR) begin
          mode     = sse_pkg::MODE_BLOCK;
          o_region = sse_pkg::REGION_BLOCK;
        end else begin
          do_code = 1'b1;
        end
      end
      sse_pkg::MODE_STRING: begin
        o_region = sse_pkg::REGION_STRING;
        if (text_byte == sse_pkg::CH_QUOTE) mode = sse_pkg::MODE_CODE;
      end
      sse_pkg::MODE_LINE: begin
        if (text_byte == sse_pkg::CH_NEWLINE) begin
          mode = sse_pkg::MODE_CODE;
        end else begin
          o_region = sse_pkg::REGION_LINE;
        end
      end
      sse_pkg::MODE_BLOCK: begin
        o_region = sse_pkg::REGION_BLOCK;
        if (text_byte == sse_pkg::CH_STAR) mode = sse_pkg::MODE_BLOCK_STAR;
      end
      sse_pkg::MODE_BLOCK_STAR: begin
        o_region = sse_pkg::REGION_BLOCK;
        if (text_byte == sse_pkg::CH_SLASH) begin
          mode = sse_pkg::MODE_CODE;
        end else if (text_byte != sse_pkg::CH_STAR) begin
          mode = sse_pkg::MODE_BLOCK;
        end
      end
      default: begin
        mode    = sse_pkg::MODE_CODE;
        do_code = 1'b1;
      end
    endcase

    if (do_code) begin
      o_region = sse_pkg::REGION_CODE;
      if (wlen != 3'd0) begin
        if (word_char) begin
          if (wlen < sse_pkg::WORD_MAX) begin
            wchars = {wchars[39:0], upper};
            wlen   = wlen + 3'd1;
          end else begin
            wlen = sse_pkg::WORD_LONG;
          end
          skip = 1'b1;
        end else begin
          if (pend == sse_pkg::PEND_BEGIN) begin
            if (!sse_pkg::word_is(wchars, wlen, sse_pkg::KW_WORK, 3'd4)) d = nest(d);
          end else if (pend == sse_pkg::PEND_END) begin
            if (!(sse_pkg::word_is(wchars, wlen, sse_pkg::KW_IF, 3'd2) ||
                  sse_pkg::word_is(wchars, wlen, sse_pkg::KW_WHILE, 3'd5) ||
                  sse_pkg::word_is(wchars, wlen, sse_pkg::KW_LOOP, 3'd4) ||
                  sse_pkg::word_is(wchars, wlen, sse_pkg::KW_REPEAT, 3'd6) ||
                  sse_pkg::word_is(wchars, wlen, sse_pkg::KW_CASE, 3'd4))) begin
              d = unnest(d);
            end
          end
          pend = sse_pkg::PEND_NONE;
          if (sse_pkg::word_is(wchars, wlen, sse_pkg::KW_BEGIN, 3'd5)) begin
            pend = sse_pkg::PEND_BEGIN;
          end else if (sse_pkg::word_is(wchars, wlen, sse_pkg::KW_END, 3'd3)) begin
            pend = sse_pkg::PEND_END;
          end
          wchars = '0;
          wlen   = '0;
        end
      end

      if (!skip && !sse_pkg::is_space(text_byte)) begin
        if (letter || (text_byte == sse_pkg::CH_UNDER)) begin
          if ((pend == sse_pkg::PEND_BEGIN) && (text_byte == sse_pkg::CH_UNDER)) begin
            d    = nest(d);
            pend = sse_pkg::PEND_NONE;
          end
          wchars = {wchars[39:0], upper};
          wlen   = wlen + 3'd1;
        end else begin
          if (pend == sse_pkg::PEND_BEGIN) begin
            if (text_byte != sse_pkg::CH_SEMI) d = nest(d);
          end else if (pend == sse_pkg::PEND_END) begin
            d = unnest(d);
          end
          pend = sse_pkg::PEND_NONE;
          if (text_byte == sse_pkg::CH_SEMI) begin
            o_end = (d == '0);
          end else if (text_byte == sse_pkg::CH_DASH) begin
            mode = sse_pkg::MODE_DASH;
          end else if (text_byte == sse_pkg::CH_SLASH) begin
            mode = sse_pkg::MODE_SLASH;
          end else if (text_byte == sse_pkg::CH_HASH) begin
            mode     = sse_pkg::MODE_LINE;
            o_region = sse_pkg::REGION_LINE;
          end else if (text_byte == sse_pkg::CH_QUOTE) begin
            mode     = sse_pkg::MODE_STRING;
            o_region = sse_pkg::REGION_STRING;
          end
        end
      end
    end

    state_next.mode        = mode;
    state_next.word_chars  = wchars;
    state_next.word_length = wlen;
    state_next.pending     = pend;
    depth_next             = d;
  end

  always_comb begin
    depth_wide = 17'(d);

    result.statement_end = o_end;
    result.nesting_depth = (depth_wide > 17'd255) ? 8'd255 : depth_wide[7:0];
    result.scan_region   = o_region;
  end

endmodule

// ===== src/sql_statement_end_scanner_top.sv =====
// A byte accepted at the input is held in the input register, passes the scan
// step into the result register and is presented at the output from there.
// One text byte per cycle while the output is not stalled, set by the single
// scan step between the input and result registers, with scan state fed back.
// Reset (rst, synchronous) empties both registers and returns the scanner to
// plain code with no word, nothing pending and depth zero.
// ----------------------------------------------------------------------------
// sql_statement_end_scanner_top
// Flags each top-level ';' in a byte stream of SQL text and reports the
// BEGIN...END nesting depth and the lexical region of every byte.
// ----------------------------------------------------------------------------
module sql_statement_end_scanner_top #(
  parameter int MAX_DEPTH = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       session_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       statement_end,
  output logic [7:0] nesting_depth,
  output logic [1:0] scan_region
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

  logic                  in_full;
  logic [7:0]            in_byte;
  logic                  in_start;
  logic                  advance;

  sse_pkg::scan_state_t  state;
  sse_pkg::scan_state_t  state_next;
  logic [DEPTH_W-1:0]    depth;
  logic [DEPTH_W-1:0]    depth_next;
  sse_pkg::scan_result_t result_next;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  sse_step #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_step (
    .text_byte    (in_byte),
    .session_start(in_start),
    .state        (state),
    .depth        (depth),
    .state_next   (state_next),
    .depth_next   (depth_next),
    .result       (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte  <= text_byte;
      in_start <= session_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode        <= sse_pkg::MODE_CODE;
      state.word_chars  <= '0;
      state.word_length <= '0;
      state.pending     <= sse_pkg::PEND_NONE;
      depth             <= '0;
    end else if (advance) begin
      state <= state_next;
      depth <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      statement_end <= result_next.statement_end;
      nesting_depth <= result_next.nesting_depth;
      scan_region   <= result_next.scan_region;
    end
  end

endmodule
